[sv/hed_pkg.sv]
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types and constants for the Hamming encoder/decoder pipeline.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int FIELD_W = 31;

  typedef struct packed {
    logic vld;
    logic enc;
  } hed_ctl_t;

endpackage

[sv/hed_map_stage.sv]
// ----------------------------------------------------------------------------
// hed_map_stage
// First stage: masks the incoming word to the codeword width and, for encode,
// spreads the data bits over the non-parity positions.
// ----------------------------------------------------------------------------
module hed_map_stage
  import hed_pkg::*;
#(
  parameter int CODE_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_req_type,
  input  logic [FIELD_W-1:0]   in_word,
  output hed_ctl_t             ctl,
  output logic [CODE_BITS-1:0] word_r
);

  localparam int SW = $clog2(CODE_BITS + 1);
  localparam int K  = CODE_BITS - SW;

  logic                 vld_r;
  logic                 enc_r;
  logic [CODE_BITS-1:0] raw;
  logic [CODE_BITS-1:0] spread;
  logic [CODE_BITS-1:0] word_nxt;

  generate
    if (CODE_BITS > FIELD_W) begin : g_wide
      assign raw = {{(CODE_BITS - FIELD_W){1'b0}}, in_word};
    end else begin : g_narrow
      assign raw = in_word[CODE_BITS-1:0];
    end

    for (genvar p = 1; p <= CODE_BITS; p++) begin : g_pos
      if ((p & (p - 1)) == 0) begin : g_par
        assign spread[CODE_BITS-p] = 1'b0;
      end else begin : g_dat
        localparam int DI = K - p + $clog2(p + 1);
        assign spread[CODE_BITS-p] = raw[DI];
      end
    end
  endgenerate

  assign word_nxt = in_req_type ? spread : raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enc_r  <= in_req_type;
      word_r <= word_nxt;
    end
  end

  assign ctl.vld = vld_r;
  assign ctl.enc = enc_r;

endmodule

[sv/hed_syn_stage.sv]
// ----------------------------------------------------------------------------
// hed_syn_stage
// Second stage: syndrome as the XOR of the numbers of all set positions.
// ----------------------------------------------------------------------------
module hed_syn_stage
  import hed_pkg::*;
#(
  parameter int CODE_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  hed_ctl_t                       ctl_in,
  input  logic [CODE_BITS-1:0]           word_in,
  output hed_ctl_t                       ctl,
  output logic [CODE_BITS-1:0]           word_r,
  output logic [$clog2(CODE_BITS+1)-1:0] syn_r
);

  localparam int SW = $clog2(CODE_BITS + 1);

  logic          vld_r;
  logic          enc_r;
  logic [SW-1:0] syn_nxt;

  always_comb begin
    syn_nxt = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (word_in[CODE_BITS-p]) begin
        syn_nxt = syn_nxt ^ SW'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enc_r  <= ctl_in.enc;
      word_r <= word_in;
      syn_r  <= syn_nxt;
    end
  end

  assign ctl.vld = vld_r;
  assign ctl.enc = enc_r;

endmodule

[sv/hed_fix_stage.sv]
// ----------------------------------------------------------------------------
// hed_fix_stage
// Third stage: inserts parity bits on encode; on decode flips the named bit,
// flags the result and extracts the data bits. Holds the output register.
// ----------------------------------------------------------------------------
module hed_fix_stage
  import hed_pkg::*;
#(
  parameter int CODE_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  hed_ctl_t                       ctl_in,
  input  logic [CODE_BITS-1:0]           word_in,
  input  logic [$clog2(CODE_BITS+1)-1:0] syn_in,
  output logic                           out_valid,
  output logic [FIELD_W-1:0]             out_word_out,
  output logic                           out_corrected,
  output logic                           out_uncorrectable
);

  localparam int SW = $clog2(CODE_BITS + 1);
  localparam int K  = CODE_BITS - SW;

  logic                 vld_r;
  logic [FIELD_W-1:0]   word_out_r;
  logic                 corrected_r;
  logic                 uncorrectable_r;
  logic [CODE_BITS-1:0] enc_word;
  logic [CODE_BITS-1:0] fixed_word;
  logic [CODE_BITS-1:0] data_word;
  logic [CODE_BITS-1:0] res;
  logic [FIELD_W-1:0]   word_out_nxt;
  logic                 corrected_nxt;
  logic                 uncorrectable_nxt;

  generate
    for (genvar p = 1; p <= CODE_BITS; p++) begin : g_pos
      assign fixed_word[CODE_BITS-p] = word_in[CODE_BITS-p] ^ (syn_in == SW'(p));
      if ((p & (p - 1)) == 0) begin : g_par
        if (p == CODE_BITS) begin : g_last
          assign enc_word[CODE_BITS-p] = 1'b0;
        end else begin : g_cov
          assign enc_word[CODE_BITS-p] = syn_in[$clog2(p)];
        end
      end else begin : g_dat
        localparam int DI = K - p + $clog2(p + 1);
        assign enc_word[CODE_BITS-p] = word_in[CODE_BITS-p];
        assign data_word[DI]         = fixed_word[CODE_BITS-p];
      end
    end

    assign data_word[CODE_BITS-1:K] = '0;

    if (CODE_BITS >= FIELD_W) begin : g_wide
      assign word_out_nxt = res[FIELD_W-1:0];
    end else begin : g_narrow
      assign word_out_nxt = {{(FIELD_W - CODE_BITS){1'b0}}, res};
    end
  endgenerate

  assign res               = ctl_in.enc ? enc_word : data_word;
  assign corrected_nxt     = !ctl_in.enc && (syn_in != '0) && (syn_in <= SW'(CODE_BITS));
  assign uncorrectable_nxt = !ctl_in.enc && (syn_in > SW'(CODE_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_out_r      <= word_out_nxt;
      corrected_r     <= corrected_nxt;
      uncorrectable_r <= uncorrectable_nxt;
    end
  end

  assign out_valid         = vld_r;
  assign out_word_out      = word_out_r;
  assign out_corrected     = corrected_r;
  assign out_uncorrectable = uncorrectable_r;

endmodule

[sv/hamming_encode_decode.sv]
// ----------------------------------------------------------------------------
// hamming_encode_decode
// Throughput: one request per cycle; the three register stages advance
// together and hold as a whole while the result is stalled.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// Hamming single-error-correcting encoder/decoder, three-stage pipeline.
// ----------------------------------------------------------------------------
module hamming_encode_decode
  import hed_pkg::*;
#(
  parameter int CODE_BITS = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [FIELD_W-1:0] in_word_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] out_word_out,
  output logic               out_corrected,
  output logic               out_uncorrectable
);

  localparam int SW = $clog2(CODE_BITS + 1);

  logic                 en;
  hed_ctl_t             ctl1;
  hed_ctl_t             ctl2;
  logic [CODE_BITS-1:0] word1;
  logic [CODE_BITS-1:0] word2;
  logic [SW-1:0]        syn2;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  hed_map_stage #(.CODE_BITS(CODE_BITS)) u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_word     (in_word_in),
    .ctl         (ctl1),
    .word_r      (word1)
  );

  hed_syn_stage #(.CODE_BITS(CODE_BITS)) u_syn (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (ctl1),
    .word_in (word1),
    .ctl     (ctl2),
    .word_r  (word2),
    .syn_r   (syn2)
  );

  hed_fix_stage #(.CODE_BITS(CODE_BITS)) u_fix (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .ctl_in            (ctl2),
    .word_in           (word2),
    .syn_in            (syn2),
    .out_valid         (out_valid),
    .out_word_out      (out_word_out),
    .out_corrected     (out_corrected),
    .out_uncorrectable (out_uncorrectable)
  );

endmodule

[tb/hamming_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_checker
// Watches both channels of the Hamming encoder/decoder. Every accepted
// request is turned into an expected codeword or data word with its flags,
// and every accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
package hamming_tb_pkg;

  typedef enum logic {
    REQ_DECODE = 1'b0,
    REQ_ENCODE = 1'b1
  } hamming_req_e;

endpackage

module hamming_checker
  import hed_pkg::*;
  import hamming_tb_pkg::*;
#(
  parameter int CODE_BITS = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_req_type,
  input  logic [FIELD_W-1:0] in_word_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [FIELD_W-1:0] out_word_out,
  input  logic               out_corrected,
  input  logic               out_uncorrectable,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [FIELD_W-1:0] word;
    logic               corrected;
    logic               uncorrectable;
  } coder_result_t;

  coder_result_t result_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic bit is_check_pos(int p);
    return (p & (p - 1)) == 0;
  endfunction

  function automatic int syndrome_of(logic [63:0] w);
    int s;
    s = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (w[CODE_BITS-p]) begin
        s ^= p;
      end
    end
    return s;
  endfunction

  function automatic coder_result_t predict_result(hamming_req_e req,
                                                   logic [FIELD_W-1:0] word);
    logic [63:0]   w;
    logic [63:0]   cw;
    logic [63:0]   data;
    int            s;
    int            k;
    int            j;
    coder_result_t r;
    w = {{(64-FIELD_W){1'b0}}, word} & ((64'd2 << (CODE_BITS - 1)) - 64'd1);
    r.corrected     = 1'b0;
    r.uncorrectable = 1'b0;
    if (req == REQ_ENCODE) begin
      k = 0;
      for (int p = 1; p <= CODE_BITS; p++) begin
        if (!is_check_pos(p)) begin
          k++;
        end
      end
      cw = '0;
      j  = 0;
      for (int p = 1; p <= CODE_BITS; p++) begin
        if (!is_check_pos(p)) begin
          if (w[k-1-j]) begin
            cw[CODE_BITS-p] = 1'b1;
          end
          j++;
        end
      end
      s = syndrome_of(cw);
      // a parity bit at the last position covers only itself and stays 0
      for (int p = 1; p <= CODE_BITS; p = p * 2) begin
        if ((s & p) != 0 && p != CODE_BITS) begin
          cw[CODE_BITS-p] = 1'b1;
        end
      end
      r.word = cw[FIELD_W-1:0];
    end else begin
      s = syndrome_of(w);
      if (s != 0) begin
        if (s <= CODE_BITS) begin
          w[CODE_BITS-s]  = ~w[CODE_BITS-s];
          r.corrected     = 1'b1;
        end else begin
          r.uncorrectable = 1'b1;
        end
      end
      data = '0;
      for (int p = 1; p <= CODE_BITS; p++) begin
        if (!is_check_pos(p)) begin
          data = {data[62:0], w[CODE_BITS-p]};
        end
      end
      r.word = data[FIELD_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    coder_result_t got;
    coder_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.word          = out_word_out;
        got.corrected     = out_corrected;
        got.uncorrectable = out_uncorrectable;
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request pending", got.word));
        end else begin
          want = result_q.pop_front();
          if (got.word !== want.word) begin
            report_mismatch($sformatf("word_out %h, expected %h", got.word, want.word));
          end
          if (got.corrected !== want.corrected) begin
            report_mismatch($sformatf("corrected %b, expected %b",
                                      got.corrected, want.corrected));
          end
          if (got.uncorrectable !== want.uncorrectable) begin
            report_mismatch($sformatf("uncorrectable %b, expected %b",
                                      got.uncorrectable, want.uncorrectable));
          end
        end
      end
      if (in_valid && !in_stall) begin
        result_q.push_back(predict_result(hamming_req_e'(in_req_type), in_word_in));
      end
    end
    outstanding <= result_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives encode and decode requests into the Hamming encoder/decoder: a
// directed set of edge patterns, then random data words and codewords with
// zero, one or two flipped bits, with random gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench
  import hed_pkg::*;
  import hamming_tb_pkg::*;
;

  localparam int CODE_BITS = 31;
  localparam int DATA_BITS = 26;
  localparam int ITEMS     = 1150;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [FIELD_W-1:0] in_word_in;
  logic               out_valid;
  logic               out_stall;
  logic [FIELD_W-1:0] out_word_out;
  logic               out_corrected;
  logic               out_uncorrectable;
  int                 mismatches;
  int                 pending;
  bit                 tx_burst;
  int                 n_encode;
  int                 n_decode;
  int                 n_damaged;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hamming_encode_decode #(
    .CODE_BITS(CODE_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_word_in       (in_word_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_out     (out_word_out),
    .out_corrected    (out_corrected),
    .out_uncorrectable(out_uncorrectable)
  );

  hamming_checker #(
    .CODE_BITS(CODE_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_word_in       (in_word_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_out     (out_word_out),
    .out_corrected    (out_corrected),
    .out_uncorrectable(out_uncorrectable),
    .mismatches       (mismatches),
    .outstanding      (pending)
  );

  // fix up the one bit named by the syndrome so the word becomes a codeword
  function automatic logic [FIELD_W-1:0] make_codeword(logic [FIELD_W-1:0] w);
    int s;
    s = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (w[CODE_BITS-p]) begin
        s ^= p;
      end
    end
    if (s != 0) begin
      w[CODE_BITS-s] = ~w[CODE_BITS-s];
    end
    return w;
  endfunction

  task automatic send_req(input hamming_req_e req, input logic [FIELD_W-1:0] word);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_word_in  <= word;
    do @(posedge clk); while (in_stall);
    if (req == REQ_ENCODE) begin
      n_encode++;
    end else begin
      n_decode++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : result_sink
    int hold;
    int taken;
    bit rx_burst;
    out_stall = 1'b0;
    taken     = 0;
    rx_burst  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      hold = rx_burst ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [31:0]        raw;
    logic [FIELD_W-1:0] cw;
    int                 sel;
    int                 p1;
    int                 p2;
    int                 one_hot_pos[6];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = 1'b0;
    in_word_in  = '0;
    tx_burst    = 1'b0;
    n_encode    = 0;
    n_decode    = 0;
    n_damaged   = 0;
    one_hot_pos = '{1, 2, 3, 16, 17, 31};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed edge patterns
    send_req(REQ_ENCODE, '0);
    send_req(REQ_ENCODE, 31'h03FF_FFFF);
    send_req(REQ_ENCODE, 31'h7FFF_FFFF);
    send_req(REQ_ENCODE, 31'h7C00_0000);
    send_req(REQ_ENCODE, 31'h0000_0001);
    send_req(REQ_ENCODE, 31'h0200_0000);
    send_req(REQ_ENCODE, 31'h02AA_AAAA);
    send_req(REQ_ENCODE, 31'h0155_5555);
    send_req(REQ_DECODE, '0);
    send_req(REQ_DECODE, 31'h7FFF_FFFF);
    foreach (one_hot_pos[i]) begin
      send_req(REQ_DECODE, 31'd1 << (CODE_BITS - one_hot_pos[i]));
    end
    cw = make_codeword(31'h5A5A_5A5A);
    send_req(REQ_DECODE, cw);
    send_req(REQ_DECODE, cw ^ (31'd1 << (CODE_BITS - 8)));
    send_req(REQ_DECODE, cw ^ (31'd1 << (CODE_BITS - 20)));
    send_req(REQ_DECODE, cw ^ (31'd1 << (CODE_BITS - 5)) ^ (31'd1 << (CODE_BITS - 9)));
    n_damaged += 9;
    drain();

    for (int i = 0; i < ITEMS; i++) begin
      if (i % 50 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
      end
      if (i == ITEMS / 3 || i == 2 * ITEMS / 3) begin
        drain();
      end
      sel = $urandom_range(0, 99);
      raw = $urandom;
      if (sel < 30) begin
        send_req(REQ_ENCODE, raw[FIELD_W-1:0] & ((31'd1 << DATA_BITS) - 31'd1));
      end else if (sel < 40) begin
        send_req(REQ_ENCODE, raw[FIELD_W-1:0]);
      end else if (sel < 94) begin
        cw = make_codeword(raw[FIELD_W-1:0]);
        p1 = $urandom_range(1, CODE_BITS);
        p2 = ((p1 + $urandom_range(0, CODE_BITS - 2)) % CODE_BITS) + 1;
        if (sel >= 62) begin
          cw[CODE_BITS-p1] = ~cw[CODE_BITS-p1];
          n_damaged++;
        end
        if (sel >= 84) begin
          cw[CODE_BITS-p2] = ~cw[CODE_BITS-p2];
        end
        send_req(REQ_DECODE, cw);
      end else begin
        send_req(REQ_DECODE, raw[FIELD_W-1:0]);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d encode and %0d decode requests, %0d codewords with flipped bits",
             n_encode, n_decode, n_damaged);
    $display("gaps and result stalls of 0 to 13 cycles, with bursts of back-to-back traffic");
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
